FILE: rtl/bwt_pkg.sv
// ----------------------------------------------------------------------------
// bwt_pkg: shared types and constants of the binary window threshold filter
// Sizes of the line store, the counters and the decoupling queue, register
// codes, and the word that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package bwt_pkg;

    // Largest supported image side and the widths that follow from it.
    localparam int MAX_SIZE = 2048;
    localparam int COL_W    = $clog2(MAX_SIZE);
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);

    // Window geometry: a 5x5 window needs four stored rows.
    localparam int WIN_SIDE  = 5;
    localparam int WIN_BITS  = WIN_SIDE * WIN_SIDE;
    localparam int LS_ROWS   = WIN_SIDE - 1;
    localparam int COUNT_W   = $clog2(WIN_BITS + 1);

    // Configuration register widths and reset values.
    localparam int IMG_W          = 12;
    localparam int MINC_W         = 5;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int SIZE_RESET     = 2048;
    localparam int MINC_RESET     = 15;

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE = 2'd0,
        REG_MIN_COUNT  = 2'd1
    } bwt_reg_t;

    // Controls from the register block to the front part.
    typedef struct packed {
        logic [SIZE_W-1:0] size;     // clamped image side
        logic              restart;  // a size write restarts the frame
    } bwt_front_ctl_t;

    // One classified pixel, as queued between the two parts.
    typedef struct packed {
        logic             pixel;
        logic [COL_W-1:0] col;
        logic             emit;      // a full window ends here
        logic             last;      // final output pixel of the frame
    } bwt_word_t;

endpackage

FILE: rtl/bwt_channels.sv
// ----------------------------------------------------------------------------
// bwt_channels: valid/ready channels of the binary window threshold filter
// The pixel channel carries one input pixel per word, the result channel one
// filtered output pixel with its end-of-frame flag.
// ----------------------------------------------------------------------------
interface bwt_in_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bwt_out_if;
    logic valid;
    logic ready;
    logic filtered;
    logic frame_last;

    modport source (output valid, output filtered, output frame_last, input ready);
    modport sink   (input valid, input filtered, input frame_last, output ready);
endinterface

FILE: rtl/bwt_ram.sv
// ----------------------------------------------------------------------------
// bwt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module bwt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bwt_front.sv
// ----------------------------------------------------------------------------
// bwt_front: pixel intake and classification
// Accepts pixels, tracks row and column in the frame, marks where a full
// window ends and where the frame's last output lies, and queues each word.
// ----------------------------------------------------------------------------
module bwt_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bwt_pkg::bwt_front_ctl_t ctl,
    bwt_in_if.sink                 pixels,
    input  logic                   q_full,
    output logic                   push,
    output bwt_pkg::bwt_word_t     push_word
);
    import bwt_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_cur, row_cur;
    logic             col_end, row_end;
    logic             accept;

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && !q_full;
    assign push         = accept;

    // Current position, guarded against a counter beyond the frame.
    always_comb
    begin
        col_cur = (SIZE_W'(col_reg) >= ctl.size) ? '0 : col_reg;
        row_cur = (SIZE_W'(row_reg) >= ctl.size) ? '0 : row_reg;
        col_end = (SIZE_W'(col_cur) == ctl.size - SIZE_W'(1));
        row_end = (SIZE_W'(row_cur) == ctl.size - SIZE_W'(1));
    end

    // Classification of the accepted pixel.
    always_comb
    begin
        push_word.pixel = pixels.pixel;
        push_word.col   = col_cur;
        push_word.emit  = (row_cur >= COL_W'(LS_ROWS)) && (col_cur >= COL_W'(LS_ROWS));
        push_word.last  = row_end && col_end;
    end

    // Raster position advance with wrap at row and frame end.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (ctl.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_cur + COL_W'(1);
            end
            else
            begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // The position stays inside the frame.
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        SIZE_W'(col_reg) < ctl.size && SIZE_W'(row_reg) < ctl.size)
        else $error("front position outside the frame");

    // The frame's last output is always an emitting position.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_word.last |-> push_word.emit)
        else $error("last flag on a border position");

endmodule

FILE: rtl/bwt_queue.sv
// ----------------------------------------------------------------------------
// bwt_queue: short FIFO between the front and back parts
// Holds classified words so that intake and processing stall independently.
// ----------------------------------------------------------------------------
module bwt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bwt_pkg::bwt_word_t push_word,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output bwt_pkg::bwt_word_t head_word
);
    import bwt_pkg::*;

    bwt_word_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

endmodule

FILE: rtl/bwt_back.sv
// ----------------------------------------------------------------------------
// bwt_back: line store, window and threshold
// Pops classified words, reads the four stored rows at the pixel's column,
// shifts the 5x5 window, counts its set pixels and drives the result register.
// ----------------------------------------------------------------------------
module bwt_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bwt_pkg::MINC_W-1:0] min_count,
    input  logic                       head_valid,
    input  bwt_pkg::bwt_word_t         head_word,
    output logic                       pop,
    bwt_out_if.source                  results
);
    import bwt_pkg::*;

    logic                s2_valid_reg;
    bwt_word_t           s2_word_reg;
    logic [WIN_BITS-1:0] win_reg, win_next;
    logic                o_valid_reg;
    logic                o_filtered_reg;
    logic                o_last_reg;
    logic                adv;
    logic [LS_ROWS-1:0]  ls_rdata;
    logic [LS_ROWS-1:0]  ls_wdata;
    logic                ls_we;
    logic [WIN_SIDE-1:0] new_column;
    logic [COUNT_W-1:0]  ones;

    // The stage moves whenever the result register is free or being taken.
    assign adv   = !o_valid_reg || results.ready;
    assign pop   = adv && head_valid;
    assign ls_we = adv && s2_valid_reg;

    // Stored rows come out oldest first; the new pixel joins at the bottom.
    always_comb
    begin
        new_column = {ls_rdata, s2_word_reg.pixel};
        ls_wdata   = {ls_rdata[LS_ROWS-2:0], s2_word_reg.pixel};
        win_next   = {win_reg[WIN_BITS-WIN_SIDE-1:0], new_column};
        ones       = COUNT_W'($countones(win_next));
    end

    // Four rows of line store, one bit per row at each column.
    bwt_ram #(
        .WIDTH (LS_ROWS),
        .DEPTH (MAX_SIZE)
    ) u_line_store (
        .clk   (clk),
        .we    (ls_we),
        .waddr (s2_word_reg.col),
        .wdata (ls_wdata),
        .re    (pop),
        .raddr (head_word.col),
        .rdata (ls_rdata)
    );

    // Processing stage, aligned with the line store read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= head_valid;
            if (s2_valid_reg)
            begin
                win_reg <= win_next;
            end
            o_valid_reg <= s2_valid_reg && s2_word_reg.emit;
        end
    end

    // Payload of the stage and the result register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_word_reg <= head_word;
        end
        if (adv)
        begin
            o_filtered_reg <= ({1'b0, ones} >= (COUNT_W + 1)'(min_count));
            o_last_reg     <= s2_word_reg.last;
        end
    end

    assign results.valid      = o_valid_reg;
    assign results.filtered   = o_filtered_reg;
    assign results.frame_last = o_last_reg;

    // A read never meets the write of the same column in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ls_we && pop |-> s2_word_reg.col != head_word.col)
        else $error("line store read and write at the same column");

    // A stalled stage keeps its word, so the window advances once per pixel.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !adv |=> s2_valid_reg && $stable(s2_word_reg) && $stable(win_reg))
        else $error("processing stage lost its word while stalled");

endmodule

FILE: rtl/binary_window_threshold_5x5_unit.sv
// ----------------------------------------------------------------------------
// binary_window_threshold_5x5_unit: 5x5 box-count threshold on binary images
// Square binary image in raster order, one pixel per word; one result word
// per full 5x5 window, set when the window holds at least min_count ones.
//
//   channel   dir  handshake       payload
//   -------   ---  -------------   ---------------------------------
//   pixels    in   valid / ready   pixel
//   results   out  valid / ready   filtered, frame_last
//   cfg       in   cfg_we only     cfg_index, cfg_data (12 bits)
//
// One pixel per cycle is sustained while results are taken; the line store's
// one read and one write per cycle set that figure. Results are registered.
// Reset clears counters, window and handshakes; the line store needs no
// clearing pass, as rows are only read after being written in the frame.
// A stalled result holds in its register while a two-word queue keeps
// accepting pixels; intake stops once that queue is full.
// ----------------------------------------------------------------------------
module binary_window_threshold_5x5_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bwt_pkg::CFG_DATA_W-1:0] cfg_data,
    bwt_in_if.sink                         pixels,
    bwt_out_if.source                      results
);
    import bwt_pkg::*;

    logic [IMG_W-1:0]  image_size_reg, image_size_next;
    logic [MINC_W-1:0] min_count_reg, min_count_next;
    logic [SIZE_W-1:0] eff_size;
    logic              size_write;
    bwt_front_ctl_t    front_ctl;
    logic              q_push, q_pop, q_full, q_head_valid;
    bwt_word_t         q_push_word, q_head_word;

    // Register writes; unknown indexes are ignored.
    always_comb
    begin
        image_size_next = image_size_reg;
        min_count_next  = min_count_reg;
        size_write      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_SIZE:
                begin
                    image_size_next = cfg_data[IMG_W-1:0];
                    size_write      = 1'b1;
                end
                REG_MIN_COUNT:
                begin
                    min_count_next = cfg_data[MINC_W-1:0];
                end
                default:
                begin
                    image_size_next = image_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= IMG_W'(SIZE_RESET);
            min_count_reg  <= MINC_W'(MINC_RESET);
        end
        else
        begin
            image_size_reg <= image_size_next;
            min_count_reg  <= min_count_next;
        end
    end

    // Clamp the image side to the supported range.
    always_comb
    begin
        if (image_size_reg < IMG_W'(WIN_SIDE))
        begin
            eff_size = SIZE_W'(WIN_SIDE);
        end
        else if (32'(image_size_reg) > MAX_SIZE)
        begin
            eff_size = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            eff_size = SIZE_W'(image_size_reg);
        end
        front_ctl.size    = eff_size;
        front_ctl.restart = size_write;
    end

    bwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (front_ctl),
        .pixels    (pixels),
        .q_full    (q_full),
        .push      (q_push),
        .push_word (q_push_word)
    );

    bwt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_push_word),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_word  (q_head_word)
    );

    bwt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_count  (min_count_reg),
        .head_valid (q_head_valid),
        .head_word  (q_head_word),
        .pop        (q_pop),
        .results    (results)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 5x5 binary window threshold filter
// Streams binary raster images through the pixel channel under several image
// sizes and thresholds, predicts every result word from a model of its own,
// and compares each accepted result word field by field with the oldest
// prediction. Both channels idle at random, and the result side holds off
// once for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------

// One predicted result word.
typedef struct {
    logic filtered;
    logic frame_last;
} window_verdict_t;

// Keeps a copy of the filter state, predicts the result words of each
// accepted pixel and checks the result words that come out of the block.
class window_scoreboard;
    logic [bwt_pkg::IMG_W-1:0]    side_reg;
    logic [bwt_pkg::MINC_W-1:0]   min_ones;
    // Per column the four previous rows, oldest row in the top bit.
    logic [bwt_pkg::LS_ROWS-1:0]  col_hist [bwt_pkg::MAX_SIZE];
    logic [bwt_pkg::WIN_BITS-1:0] window;
    int unsigned                  row_pos;
    int unsigned                  col_pos;
    window_verdict_t              verdicts_due[$];
    int                           errors;
    int                           checked;
    int                           frame_ends;
    int                           max_shown;

    function new();
        side_reg   = bwt_pkg::SIZE_RESET;
        min_ones   = bwt_pkg::MINC_RESET;
        window     = '0;
        row_pos    = 0;
        col_pos    = 0;
        errors     = 0;
        checked    = 0;
        frame_ends = 0;
        max_shown  = 40;
        foreach (col_hist[i])
        begin
            col_hist[i] = '0;
        end
    endfunction

    // A size write restarts the frame; unknown indexes are ignored.
    function void set_reg(logic [bwt_pkg::CFG_IDX_W-1:0] idx,
                          logic [bwt_pkg::CFG_DATA_W-1:0] data);
        if (idx == bwt_pkg::REG_IMAGE_SIZE)
        begin
            side_reg = data[bwt_pkg::IMG_W-1:0];
            row_pos  = 0;
            col_pos  = 0;
        end
        else if (idx == bwt_pkg::REG_MIN_COUNT)
        begin
            min_ones = data[bwt_pkg::MINC_W-1:0];
        end
    endfunction

    function int pending_count();
        return verdicts_due.size();
    endfunction

    // Advance the window by one accepted pixel and queue the result word
    // that it causes, if a full window ends here.
    function void note_pixel(logic px);
        int unsigned                  side;
        int unsigned                  c;
        int unsigned                  r;
        logic [bwt_pkg::WIN_SIDE-1:0] column;
        window_verdict_t              v;
        side = side_reg;
        if (side < bwt_pkg::WIN_SIDE)
            side = bwt_pkg::WIN_SIDE;
        if (side > bwt_pkg::MAX_SIZE)
            side = bwt_pkg::MAX_SIZE;
        c = (col_pos >= side) ? 0 : col_pos;
        r = (row_pos >= side) ? 0 : row_pos;

        // New window column: stored rows on top, incoming pixel at the bottom.
        column      = {col_hist[c], px};
        col_hist[c] = {col_hist[c][bwt_pkg::LS_ROWS-2:0], px};
        window      = {window[bwt_pkg::WIN_BITS-bwt_pkg::WIN_SIDE-1:0], column};

        // The first four rows and columns of a frame give no result.
        if (r >= bwt_pkg::LS_ROWS && c >= bwt_pkg::LS_ROWS)
        begin
            v.filtered   = (int'($countones(window)) >= int'(min_ones));
            v.frame_last = (r == side - 1 && c == side - 1);
            verdicts_due.push_back(v);
        end

        c++;
        if (c >= side)
        begin
            c = 0;
            r++;
            if (r >= side)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task report(string what);
        errors++;
        if (errors <= max_shown)
            $display("[%0t] mismatch at result word %0d: %s", $time, checked, what);
    endtask

    // Compare one accepted result word with the oldest prediction.
    task check_result(logic filtered, logic frame_last);
        window_verdict_t want;
        checked++;
        if (frame_last === 1'b1)
            frame_ends++;
        if (verdicts_due.size() == 0)
        begin
            report($sformatf("result word with nothing pending (filtered=%b last=%b)",
                             filtered, frame_last));
        end
        else
        begin
            want = verdicts_due.pop_front();
            if (filtered !== want.filtered)
                report($sformatf("filtered=%b, predicted %b", filtered, want.filtered));
            if (frame_last !== want.frame_last)
                report($sformatf("frame_last=%b, predicted %b", frame_last,
                                 want.frame_last));
        end
    endtask
endclass

module tb_top;
    import bwt_pkg::*;

    localparam int          CLK_HALF      = 4;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          LONG_HOLD     = 400;
    localparam int          WIDE_PIXELS   = 200;
    localparam int          RANDOM_PIXELS = 1400;
    localparam int unsigned CYCLE_LIMIT   = 6000000;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bwt_in_if  pix_ch ();
    bwt_out_if res_ch ();

    window_scoreboard sb = new();

    bit source_steady;
    bit in_random;
    int pixels_sent;
    int settings_run;
    int long_holds;

    binary_window_threshold_5x5_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one register write, then drop the write enable and leave the port quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Send count pixels, each set with a chance of dens percent.
    task automatic stream_pixels(input int count, input int dens);
        int   i;
        int   gap;
        logic px;
        for (i = 0; i < count; i++)
        begin
            px  = ($urandom_range(99) < dens);
            gap = source_steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_ch.valid <= 1'b1;
            pix_ch.pixel <= px;
            @(posedge clk);
            while (!pix_ch.ready)
                @(posedge clk);
            sb.note_pixel(px);
            pixels_sent++;
        end
        pix_ch.valid <= 1'b0;
    endtask

    // Wait until every predicted word has come, then let the pipeline empty.
    task automatic settle();
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int mode_left;
        bit steady;
        bit held_once;
        stall_left   = 0;
        hold_left    = 0;
        mode_left    = 0;
        steady       = 1'b0;
        held_once    = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.filtered, res_ch.frame_last);

            // The first result of the random part starts the long hold-off.
            if (!held_once && in_random && res_ch.valid)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
                long_holds++;
            end

            if (mode_left == 0)
            begin
                steady    = ($urandom_range(3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            else
            begin
                mode_left--;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && !steady && $urandom_range(3) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end
                else
                begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Hang guard.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int r;
        int side_v;
        int cur_side;
        int minc;
        int count;
        int dens;
        int start_px;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= 1'b0;
        in_random    <= 1'b0;
        source_steady = 1'b0;
        pixels_sent   = 0;
        settings_run  = 0;
        long_holds    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: largest image, so the first rows give no result.
        stream_pixels(WIDE_PIXELS, 60);
        settle();
        settings_run++;

        // Smallest frame, written below range, all set, strictest threshold.
        write_reg(REG_IMAGE_SIZE, 3);
        write_reg(REG_MIN_COUNT, 25);
        stream_pixels(WIN_BITS, 100);
        settle();
        settings_run++;
        cur_side = WIN_SIDE;

        // Random settings, a few fixed ones first.
        in_random <= 1'b1;
        start_px  = pixels_sent;
        k         = 0;
        while (pixels_sent - start_px < RANDOM_PIXELS)
        begin
            source_steady = ($urandom_range(3) == 0);
            case (k)
                0:
                begin
                    // Steady input while the output holds off.
                    write_reg(REG_IMAGE_SIZE, 12);
                    write_reg(REG_MIN_COUNT, 13);
                    cur_side      = 12;
                    count         = 3 * 144;
                    dens          = 50;
                    source_steady = 1'b1;
                end
                1:
                begin
                    // Size zero acts as the smallest; threshold zero always passes.
                    write_reg(REG_IMAGE_SIZE, 0);
                    write_reg(REG_MIN_COUNT, 0);
                    cur_side = WIN_SIDE;
                    count    = 2 * WIN_BITS;
                    dens     = 0;
                end
                2:
                begin
                    // A threshold above the window size never passes.
                    write_reg(REG_IMAGE_SIZE, 4);
                    write_reg(REG_MIN_COUNT, 12'hFFF);
                    cur_side = WIN_SIDE;
                    count    = 2 * WIN_BITS;
                    dens     = 100;
                end
                3:
                begin
                    // Frame goes on: threshold change and ignored writes only.
                    write_reg(REG_SPARE_2, 12'hFFF);
                    write_reg(REG_SPARE_3, 12'h5A5);
                    write_reg(REG_MIN_COUNT, 26);
                    count = 37;
                    dens  = 90;
                end
                default:
                begin
                    r = $urandom_range(99);
                    if (r >= 10)
                    begin
                        if (r < 60)
                            side_v = $urandom_range(5, 12);
                        else if (r < 75)
                            side_v = $urandom_range(0, 4);
                        else
                            side_v = $urandom_range(13, 40);
                        write_reg(REG_IMAGE_SIZE, CFG_DATA_W'(side_v));
                        cur_side = (side_v < WIN_SIDE) ? WIN_SIDE : side_v;
                    end
                    r = $urandom_range(99);
                    if (r < 15)
                        minc = 0;
                    else if (r < 30)
                        minc = $urandom_range(25, 31);
                    else
                        minc = $urandom_range(1, 24);
                    write_reg(REG_MIN_COUNT,
                              CFG_DATA_W'(($urandom_range(127) << MINC_W) | minc));
                    if ($urandom_range(4) == 0)
                        write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2,
                                  CFG_DATA_W'($urandom_range(4095)));

                    if (cur_side <= 12)
                    begin
                        count = $urandom_range(1, 3) * cur_side * cur_side;
                        if ($urandom_range(1) == 1)
                            count += $urandom_range(1, cur_side * cur_side - 1);
                    end
                    else
                    begin
                        count = $urandom_range(5 * cur_side, cur_side * cur_side);
                    end

                    r = $urandom_range(99);
                    if (r < 10)
                        dens = 0;
                    else if (r < 20)
                        dens = 100;
                    else
                        dens = $urandom_range(15, 90);
                end
            endcase
            stream_pixels(count, dens);
            settle();
            settings_run++;
            k++;
        end

        // Size far above range acts as the largest, so again no result comes.
        source_steady = 1'b0;
        write_reg(REG_IMAGE_SIZE, 12'hFFF);
        write_reg(REG_MIN_COUNT, 20);
        stream_pixels(WIDE_PIXELS, 70);
        settle();
        settings_run++;

        $display("Sent %0d pixels under %0d register settings; %0d result words checked.",
                 pixels_sent, settings_run, sb.checked);
        $display("Frame ends seen: %0d; long output hold-offs: %0d; mismatches: %0d.",
                 sb.frame_ends, long_holds, sb.errors);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
